// File: rtl/crpw_pkg.sv
// crpw_pkg: shared types, codes and constants of the clipped rectangle pixel writer
// no dependencies; used by every module of the block
`default_nettype none

package crpw_pkg;

    localparam int ADDR_W     = 32;
    localparam int COLOR_W    = 16;
    localparam int LIMIT_W    = 10;
    localparam int SHIFT_W    = 4;
    localparam int ACTION_W   = 3;
    localparam int MASK_W     = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam int COORD_BITS_DEF = 10;

    localparam logic [ADDR_W-1:0]  FRAME_BASE_RST = '0;
    localparam logic [LIMIT_W-1:0] X_LIMIT_RST    = LIMIT_W'(320);
    localparam logic [LIMIT_W-1:0] Y_LIMIT_RST    = LIMIT_W'(240);
    localparam logic [SHIFT_W-1:0] ROW_SHIFT_RST  = SHIFT_W'(9);

    typedef enum logic [ACTION_W-1:0] {
        ACT_PIXEL  = 3'd0,
        ACT_FILL   = 3'd1,
        ACT_HLINE  = 3'd2,
        ACT_BITMAP = 3'd3,
        ACT_STEP   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_FILL   = 2'd1,
        MODE_HLINE  = 2'd2,
        MODE_BITMAP = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOB   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_IDLE  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_BASE = 2'd0,
        CFG_X_LIMIT    = 2'd1,
        CFG_Y_LIMIT    = 2'd2,
        CFG_ROW_SHIFT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0]  frame_base;
        logic [LIMIT_W-1:0] x_limit;
        logic [LIMIT_W-1:0] y_limit;
        logic [SHIFT_W-1:0] row_shift;
    } t_cfg;

    typedef struct packed {
        t_status            status;
        logic               write_enable;
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/clipped_rect_pixel_writer.sv
// clipped_rect_pixel_writer: an accepted item goes from the input register
// through decode and run logic into the result register
// throughput 1 item per cycle when not stalled; run state updates once per item
// reset: synchronous active low; clears pipeline valids and the active run,
// loads frame_base 0, x_limit 320, y_limit 240, row_shift 9
// depends on crpw_pkg, crpw_cfg_regs, crpw_engine, crpw_addr_gen
`default_nettype none

module clipped_rect_pixel_writer #(
    parameter int COORD_BITS = crpw_pkg::COORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [crpw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [crpw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [crpw_pkg::ACTION_W-1:0]    i_action,
    input  wire logic [COORD_BITS-1:0]            i_pos_x,
    input  wire logic [COORD_BITS-1:0]            i_pos_y,
    input  wire logic [COORD_BITS-1:0]            i_extent_w,
    input  wire logic [COORD_BITS-1:0]            i_extent_h,
    input  wire logic [crpw_pkg::COLOR_W-1:0]     i_color,
    input  wire logic [crpw_pkg::MASK_W-1:0]      i_mask_value,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [1:0]                            o_status,
    output logic                                  o_write_enable,
    output logic [crpw_pkg::ADDR_W-1:0]           o_pixel_address,
    output logic [crpw_pkg::COLOR_W-1:0]          o_pixel_color,
    output logic                                  o_last
);

    crpw_pkg::t_cfg    cfg;
    crpw_pkg::t_result eng_result;

    logic                          r_in_vld;
    logic [crpw_pkg::ACTION_W-1:0] r_action;
    logic [COORD_BITS-1:0]         r_pos_x, r_pos_y, r_extent_w, r_extent_h;
    logic [crpw_pkg::COLOR_W-1:0]  r_color;
    logic [crpw_pkg::MASK_W-1:0]   r_mask_value;
    logic                          r_out_vld;
    crpw_pkg::t_result             r_result;

    logic out_free;
    logic fire;
    logic in_take;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    crpw_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    crpw_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_cfg        (cfg),
        .i_action     (r_action),
        .i_pos_x      (r_pos_x),
        .i_pos_y      (r_pos_y),
        .i_extent_w   (r_extent_w),
        .i_extent_h   (r_extent_h),
        .i_color      (r_color),
        .i_mask_value (r_mask_value),
        .o_result     (eng_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action     <= i_action;
            r_pos_x      <= i_pos_x;
            r_pos_y      <= i_pos_y;
            r_extent_w   <= i_extent_w;
            r_extent_h   <= i_extent_h;
            r_color      <= i_color;
            r_mask_value <= i_mask_value;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= eng_result;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_result.status;
    assign o_write_enable  = r_result.write_enable;
    assign o_pixel_address = r_result.pixel_address;
    assign o_pixel_color   = r_result.pixel_color;
    assign o_last          = r_result.last;

`ifndef ASSERT_OFF
    a_we_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_result.write_enable) |-> (r_result.status == crpw_pkg::ST_OK))
        else $error("pixel write with non-ok status");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_result.write_enable)
        |-> (r_result.pixel_address == '0 && r_result.pixel_color == '0))
        else $error("address or color not zero without a write");

    a_idle_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_result.status == crpw_pkg::ST_IDLE) |-> !r_result.last)
        else $error("last flagged with no command active");

    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_vld)
        else $error("input stage lost an item under stall");
`endif

endmodule

`default_nettype wire

// File: rtl/crpw_cfg_regs.sv
// crpw_cfg_regs: configuration registers written through a plain write port
// depends on crpw_pkg
`default_nettype none

module crpw_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [crpw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [crpw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output crpw_pkg::t_cfg                        o_cfg
);

    crpw_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base <= crpw_pkg::FRAME_BASE_RST;
            r_cfg.x_limit    <= crpw_pkg::X_LIMIT_RST;
            r_cfg.y_limit    <= crpw_pkg::Y_LIMIT_RST;
            r_cfg.row_shift  <= crpw_pkg::ROW_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (crpw_pkg::t_cfg_idx'(i_cfg_index))
                crpw_pkg::CFG_FRAME_BASE: begin
                    r_cfg.frame_base <= i_cfg_data[crpw_pkg::ADDR_W-1:0];
                end
                crpw_pkg::CFG_X_LIMIT: begin
                    r_cfg.x_limit <= i_cfg_data[crpw_pkg::LIMIT_W-1:0];
                end
                crpw_pkg::CFG_Y_LIMIT: begin
                    r_cfg.y_limit <= i_cfg_data[crpw_pkg::LIMIT_W-1:0];
                end
                crpw_pkg::CFG_ROW_SHIFT: begin
                    r_cfg.row_shift <= i_cfg_data[crpw_pkg::SHIFT_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/crpw_addr_gen.sv
// crpw_addr_gen: frame buffer byte address base + 2*((y << shift) + x), modulo 2^32
// depends on crpw_pkg
`default_nettype none

module crpw_addr_gen #(
    parameter int COORD_BITS = crpw_pkg::COORD_BITS_DEF
) (
    input  wire logic [COORD_BITS:0]               i_x,
    input  wire logic [COORD_BITS:0]               i_y,
    input  wire logic [crpw_pkg::SHIFT_W-1:0]      i_shift,
    input  wire logic [crpw_pkg::ADDR_W-1:0]       i_base,
    output logic      [crpw_pkg::ADDR_W-1:0]       o_addr
);

    logic [crpw_pkg::ADDR_W-1:0] row_ofs;
    logic [crpw_pkg::ADDR_W-1:0] pix_ofs;

    assign row_ofs = crpw_pkg::ADDR_W'(i_y) << i_shift;
    assign pix_ofs = row_ofs + crpw_pkg::ADDR_W'(i_x);
    assign o_addr  = i_base + {pix_ofs[crpw_pkg::ADDR_W-2:0], 1'b0};

endmodule

`default_nettype wire

// File: rtl/crpw_engine.sv
// crpw_engine: command decode, clipping, run state and per-item result
// depends on crpw_pkg and crpw_addr_gen
`default_nettype none

module crpw_engine #(
    parameter int COORD_BITS = crpw_pkg::COORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_fire,
    input  wire crpw_pkg::t_cfg                    i_cfg,
    input  wire logic [crpw_pkg::ACTION_W-1:0]     i_action,
    input  wire logic [COORD_BITS-1:0]             i_pos_x,
    input  wire logic [COORD_BITS-1:0]             i_pos_y,
    input  wire logic [COORD_BITS-1:0]             i_extent_w,
    input  wire logic [COORD_BITS-1:0]             i_extent_h,
    input  wire logic [crpw_pkg::COLOR_W-1:0]      i_color,
    input  wire logic [crpw_pkg::MASK_W-1:0]       i_mask_value,
    output crpw_pkg::t_result                      o_result
);

    localparam int S = COORD_BITS + 1;
    localparam int W = ((COORD_BITS > crpw_pkg::LIMIT_W) ? COORD_BITS : crpw_pkg::LIMIT_W) + 1;

    crpw_pkg::t_mode              r_mode, n_mode;
    logic [S-1:0]                 r_cur_x, n_cur_x;
    logic [S-1:0]                 r_cur_y, n_cur_y;
    logic [S-1:0]                 r_row_start_x, n_row_start_x;
    logic [S-1:0]                 r_run_end_x, n_run_end_x;
    logic [S-1:0]                 r_clip_end_x, n_clip_end_x;
    logic [S-1:0]                 r_run_end_y, n_run_end_y;
    logic [crpw_pkg::COLOR_W-1:0] r_color, n_color;

    crpw_pkg::t_action act;
    logic [W-1:0] px_w, py_w, ew_w, eh_w, xl_w, yl_w;
    logic [W-1:0] sum_x, sum_y, clip_x, clip_y;
    logic [W-1:0] hl_a, hl_b, hl_bc;
    logic         pt_oob, rect_empty, hl_oob, mask_pos;
    logic [S-1:0] step_nx, step_ny;
    logic         step_wrap, step_end, step_we;
    logic [S-1:0] ag_x, ag_y;
    logic [crpw_pkg::ADDR_W-1:0] ag_addr;

    assign act  = crpw_pkg::t_action'(i_action);
    assign px_w = W'(i_pos_x);
    assign py_w = W'(i_pos_y);
    assign ew_w = W'(i_extent_w);
    assign eh_w = W'(i_extent_h);
    assign xl_w = W'(i_cfg.x_limit);
    assign yl_w = W'(i_cfg.y_limit);

    // rectangle bounds, exclusive and clipped
    assign sum_x      = px_w + ew_w;
    assign sum_y      = py_w + eh_w;
    assign clip_x     = (sum_x < xl_w) ? sum_x : xl_w;
    assign clip_y     = (sum_y < yl_w) ? sum_y : yl_w;
    assign pt_oob     = (px_w >= xl_w) || (py_w >= yl_w);
    assign rect_empty = (i_extent_w == '0) || (i_extent_h == '0);

    // line ends ordered, far end clipped inclusive
    assign hl_a   = (px_w > ew_w) ? ew_w : px_w;
    assign hl_b   = (px_w > ew_w) ? px_w : ew_w;
    assign hl_bc  = (hl_b < (xl_w - W'(1))) ? hl_b : (xl_w - W'(1));
    assign hl_oob = (hl_a >= xl_w) || (py_w >= yl_w);

    assign mask_pos = (i_mask_value != '0) && !i_mask_value[crpw_pkg::MASK_W-1];

    // run walk
    assign step_nx   = r_cur_x + S'(1);
    assign step_ny   = r_cur_y + S'(1);
    assign step_wrap = step_nx >= r_run_end_x;
    assign step_end  = step_wrap && (step_ny >= r_run_end_y);
    assign step_we   = (r_cur_x < r_clip_end_x)
                       && ((r_mode != crpw_pkg::MODE_BITMAP) || mask_pos);

    assign ag_x = (act == crpw_pkg::ACT_STEP) ? r_cur_x : S'(i_pos_x);
    assign ag_y = (act == crpw_pkg::ACT_STEP) ? r_cur_y : S'(i_pos_y);

    crpw_addr_gen #(
        .COORD_BITS (COORD_BITS)
    ) u_addr_gen (
        .i_x     (ag_x),
        .i_y     (ag_y),
        .i_shift (i_cfg.row_shift),
        .i_base  (i_cfg.frame_base),
        .o_addr  (ag_addr)
    );

    // next state
    always_comb begin
        n_mode        = r_mode;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_row_start_x = r_row_start_x;
        n_run_end_x   = r_run_end_x;
        n_clip_end_x  = r_clip_end_x;
        n_run_end_y   = r_run_end_y;
        n_color       = r_color;
        case (act)
            crpw_pkg::ACT_PIXEL: begin
                n_mode = crpw_pkg::MODE_NONE;
            end
            crpw_pkg::ACT_FILL, crpw_pkg::ACT_BITMAP: begin
                n_mode = crpw_pkg::MODE_NONE;
                if (!pt_oob && !rect_empty) begin
                    n_mode        = (act == crpw_pkg::ACT_FILL) ? crpw_pkg::MODE_FILL
                                                                 : crpw_pkg::MODE_BITMAP;
                    n_cur_x       = S'(i_pos_x);
                    n_cur_y       = S'(i_pos_y);
                    n_row_start_x = S'(i_pos_x);
                    n_clip_end_x  = S'(clip_x);
                    n_run_end_x   = (act == crpw_pkg::ACT_BITMAP) ? S'(sum_x) : S'(clip_x);
                    n_run_end_y   = S'(clip_y);
                    n_color       = i_color;
                end
            end
            crpw_pkg::ACT_HLINE: begin
                n_mode = crpw_pkg::MODE_NONE;
                if (!hl_oob) begin
                    n_mode        = crpw_pkg::MODE_HLINE;
                    n_cur_x       = S'(hl_a);
                    n_cur_y       = S'(i_pos_y);
                    n_row_start_x = S'(hl_a);
                    n_run_end_x   = S'(hl_bc) + S'(1);
                    n_clip_end_x  = S'(hl_bc) + S'(1);
                    n_run_end_y   = S'(i_pos_y) + S'(1);
                    n_color       = i_color;
                end
            end
            crpw_pkg::ACT_STEP: begin
                if (r_mode != crpw_pkg::MODE_NONE) begin
                    n_cur_x = step_wrap ? r_row_start_x : step_nx;
                    if (step_wrap) begin
                        n_cur_y = step_ny;
                    end
                    if (step_end) begin
                        n_mode = crpw_pkg::MODE_NONE;
                    end
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // result
    always_comb begin
        o_result        = '0;
        o_result.status = crpw_pkg::ST_OK;
        case (act)
            crpw_pkg::ACT_PIXEL: begin
                o_result.last = 1'b1;
                if (pt_oob) begin
                    o_result.status = crpw_pkg::ST_OOB;
                end else begin
                    o_result.write_enable  = 1'b1;
                    o_result.pixel_address = ag_addr;
                    o_result.pixel_color   = i_color;
                end
            end
            crpw_pkg::ACT_FILL, crpw_pkg::ACT_BITMAP: begin
                if (pt_oob) begin
                    o_result.status = crpw_pkg::ST_OOB;
                    o_result.last   = 1'b1;
                end else if (rect_empty) begin
                    o_result.status = crpw_pkg::ST_EMPTY;
                    o_result.last   = 1'b1;
                end
            end
            crpw_pkg::ACT_HLINE: begin
                if (hl_oob) begin
                    o_result.status = crpw_pkg::ST_OOB;
                    o_result.last   = 1'b1;
                end
            end
            crpw_pkg::ACT_STEP: begin
                if (r_mode == crpw_pkg::MODE_NONE) begin
                    o_result.status = crpw_pkg::ST_IDLE;
                end else begin
                    o_result.last = step_end;
                    if (step_we) begin
                        o_result.write_enable  = 1'b1;
                        o_result.pixel_address = ag_addr;
                        o_result.pixel_color   = r_color;
                    end
                end
            end
            default: begin
                o_result.status = crpw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= crpw_pkg::MODE_NONE;
        end else if (i_fire) begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_row_start_x <= n_row_start_x;
            r_run_end_x   <= n_run_end_x;
            r_clip_end_x  <= n_clip_end_x;
            r_run_end_y   <= n_run_end_y;
            r_color       <= n_color;
        end
    end

endmodule

`default_nettype wire

// File: bench/clipped_rect_pixel_writer_tb.sv
// clipped_rect_pixel_writer_tb: self-checking bench for the clipped rectangle pixel writer
// holds a scoreboard class that predicts every result and plain tasks that drive the ports
// depends on crpw_pkg and clipped_rect_pixel_writer
import crpw_pkg::*;

typedef logic [COORD_BITS_DEF-1:0] t_coord;
typedef logic [COORD_BITS_DEF:0]   t_run_coord;

class pixel_write_scoreboard;
    logic [ADDR_W-1:0]  frame_base;
    logic [LIMIT_W-1:0] x_limit;
    logic [LIMIT_W-1:0] y_limit;
    logic [SHIFT_W-1:0] row_shift;
    t_mode              run_mode;
    t_run_coord         cur_x;
    t_run_coord         cur_y;
    t_run_coord         row_x0;
    t_run_coord         walk_end_x;
    t_run_coord         write_end_x;
    t_run_coord         end_y;
    logic [COLOR_W-1:0] run_color;
    t_result            pending_q[$];
    int                 n_results;
    int                 n_writes;
    int                 n_errors;

    function new();
        frame_base  = FRAME_BASE_RST;
        x_limit     = X_LIMIT_RST;
        y_limit     = Y_LIMIT_RST;
        row_shift   = ROW_SHIFT_RST;
        run_mode    = MODE_NONE;
        cur_x       = '0;
        cur_y       = '0;
        row_x0      = '0;
        walk_end_x  = '0;
        write_end_x = '0;
        end_y       = '0;
        run_color   = '0;
        n_results   = 0;
        n_writes    = 0;
        n_errors    = 0;
    endfunction

    function logic [ADDR_W-1:0] byte_addr(t_run_coord x, t_run_coord y);
        logic [63:0] offset;
        offset = (64'(y) << row_shift) + 64'(x);
        return ADDR_W'(64'(frame_base) + 2 * offset);
    endfunction

    function void note_item(logic [ACTION_W-1:0] act, t_coord px, t_coord py, t_coord ew,
                            t_coord eh, logic [COLOR_W-1:0] col, logic [MASK_W-1:0] mask);
        t_result    r;
        t_run_coord lo;
        t_run_coord hi;
        t_run_coord sum_x;
        t_run_coord sum_y;
        r = '0;
        r.status = ST_OK;
        if (act > ACT_STEP) begin
            r.status = ST_IDLE;
        end else if (act == ACT_STEP) begin
            if (run_mode == MODE_NONE) begin
                r.status = ST_IDLE;
            end else begin
                if (cur_x < write_end_x && (run_mode != MODE_BITMAP || $signed(mask) > 0)) begin
                    r.write_enable  = 1'b1;
                    r.pixel_address = byte_addr(cur_x, cur_y);
                    r.pixel_color   = run_color;
                end
                cur_x = cur_x + 1'b1;
                if (cur_x >= walk_end_x) begin
                    cur_x = row_x0;
                    cur_y = cur_y + 1'b1;
                    if (cur_y >= end_y) begin
                        r.last   = 1'b1;
                        run_mode = MODE_NONE;
                    end
                end
            end
        end else begin
            // any command ends the run in progress
            run_mode = MODE_NONE;
            r.last   = 1'b1;
            if (act == ACT_PIXEL) begin
                if (px >= x_limit || py >= y_limit) begin
                    r.status = ST_OOB;
                end else begin
                    r.write_enable  = 1'b1;
                    r.pixel_address = byte_addr(px, py);
                    r.pixel_color   = col;
                end
            end else if (act == ACT_HLINE) begin
                lo = (px > ew) ? ew : px;
                hi = (px > ew) ? px : ew;
                if (lo >= x_limit || py >= y_limit) begin
                    r.status = ST_OOB;
                end else begin
                    if (hi >= x_limit) begin
                        hi = t_run_coord'(x_limit) - 1'b1;
                    end
                    row_x0      = lo;
                    cur_x       = lo;
                    cur_y       = py;
                    walk_end_x  = hi + 1'b1;
                    write_end_x = walk_end_x;
                    end_y       = t_run_coord'(py) + 1'b1;
                    run_color   = col;
                    run_mode    = MODE_HLINE;
                    r.last      = 1'b0;
                end
            end else if (px >= x_limit || py >= y_limit) begin
                r.status = ST_OOB;
            end else if (ew == '0 || eh == '0) begin
                r.status = ST_EMPTY;
            end else begin
                sum_x       = t_run_coord'(px) + t_run_coord'(ew);
                sum_y       = t_run_coord'(py) + t_run_coord'(eh);
                row_x0      = px;
                cur_x       = px;
                cur_y       = py;
                write_end_x = (sum_x < x_limit) ? sum_x : t_run_coord'(x_limit);
                // bitmap walks the full width so the mask stride stays the rectangle width
                walk_end_x  = (act == ACT_BITMAP) ? sum_x : write_end_x;
                end_y       = (sum_y < y_limit) ? sum_y : t_run_coord'(y_limit);
                run_color   = col;
                run_mode    = (act == ACT_BITMAP) ? MODE_BITMAP : MODE_FILL;
                r.last      = 1'b0;
            end
        end
        pending_q.push_back(r);
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (pending_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) begin
                $display("unexpected result: status %0d we %0b addr %h color %h last %0b",
                         got.status, got.write_enable, got.pixel_address, got.pixel_color,
                         got.last);
            end
            return;
        end
        want = pending_q.pop_front();
        n_results++;
        if (want.write_enable) begin
            n_writes++;
        end
        if (got.status !== want.status || got.write_enable !== want.write_enable ||
            got.pixel_address !== want.pixel_address || got.pixel_color !== want.pixel_color ||
            got.last !== want.last) begin
            n_errors++;
            if (n_errors <= 10) begin
                $display({"result %0d differs: want status %0d we %0b addr %h color %h last %0b",
                          ", got status %0d we %0b addr %h color %h last %0b"},
                         n_results, want.status, want.write_enable, want.pixel_address,
                         want.pixel_color, want.last, got.status, got.write_enable,
                         got.pixel_address, got.pixel_color, got.last);
            end
        end
    endfunction
endclass

module clipped_rect_pixel_writer_tb;
    localparam int QUIET_LIMIT = 1000;
    localparam logic [ACTION_W-1:0] ACT_RSVD_LO = ACT_STEP + 1;
    localparam logic [ACTION_W-1:0] ACT_RSVD_HI = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_FRAME_BASE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [ACTION_W-1:0]   i_action = ACT_PIXEL;
    t_coord                i_pos_x = '0;
    t_coord                i_pos_y = '0;
    t_coord                i_extent_w = '0;
    t_coord                i_extent_h = '0;
    logic [COLOR_W-1:0]    i_color = '0;
    logic [MASK_W-1:0]     i_mask_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_status;
    logic                  o_write_enable;
    logic [ADDR_W-1:0]     o_pixel_address;
    logic [COLOR_W-1:0]    o_pixel_color;
    logic                  o_last;

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int n_items = 0;
    int n_settings = 0;
    int quiet_cycles = 0;
    pixel_write_scoreboard sb;

    clipped_rect_pixel_writer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_extent_w      (i_extent_w),
        .i_extent_h      (i_extent_h),
        .i_color         (i_color),
        .i_mask_value    (i_mask_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_write_enable  (o_write_enable),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last          (o_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status        = t_status'(o_status);
            got.write_enable  = o_write_enable;
            got.pixel_address = o_pixel_address;
            got.pixel_color   = o_pixel_color;
            got.last          = o_last;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("clipped_rect_pixel_writer: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [ACTION_W-1:0] act, input t_coord px, input t_coord py,
                             input t_coord ew, input t_coord eh, input logic [COLOR_W-1:0] col,
                             input logic [MASK_W-1:0] mask);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_pos_x      <= px;
        i_pos_y      <= py;
        i_extent_w   <= ew;
        i_extent_h   <= eh;
        i_color      <= col;
        i_mask_value <= mask;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_item(act, px, py, ew, eh, col, mask);
        n_items++;
    endtask

    task automatic send_step(input logic [MASK_W-1:0] mask);
        send_item(ACT_STEP, t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                  t_coord'($urandom), COLOR_W'($urandom), mask);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [ADDR_W-1:0] base, input logic [LIMIT_W-1:0] xl,
                              input logic [LIMIT_W-1:0] yl, input logic [SHIFT_W-1:0] sh);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FRAME_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        i_cfg_index <= CFG_X_LIMIT;
        i_cfg_data  <= CFG_DATA_W'(xl);
        @(posedge i_clk);
        i_cfg_index <= CFG_Y_LIMIT;
        i_cfg_data  <= CFG_DATA_W'(yl);
        @(posedge i_clk);
        i_cfg_index <= CFG_ROW_SHIFT;
        i_cfg_data  <= CFG_DATA_W'(sh);
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        sb.frame_base = base;
        sb.x_limit    = xl;
        sb.y_limit    = yl;
        sb.row_shift  = sh;
        n_settings++;
    endtask

    // mostly in bounds, biased to the edges, with some off-screen picks
    function automatic t_coord pick_coord(input t_coord lim);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return lim;
        if (r < 10) return t_coord'($urandom);
        if (r < 30) return lim - 1'b1 - t_coord'($urandom_range(0, (lim > 4) ? 3 : lim - 1));
        if (r < 38) return '0;
        return t_coord'($urandom_range(0, lim - 1));
    endfunction

    function automatic t_coord pick_extent();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 9) return '1;
        if (r < 20) return t_coord'($urandom_range(1, 24));
        return t_coord'($urandom_range(1, 5));
    endfunction

    task automatic random_sequence();
        int unsigned         pick;
        int unsigned         step_cap;
        int unsigned         n_steps;
        logic [ACTION_W-1:0] act;
        t_coord              px;
        t_coord              py;
        t_coord              ew;
        t_coord              eh;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            send_item(ACTION_W'($urandom), t_coord'($urandom), t_coord'($urandom),
                      t_coord'($urandom), t_coord'($urandom), COLOR_W'($urandom),
                      MASK_W'($urandom));
        end else if (pick < 16) begin
            send_step(MASK_W'($urandom));
        end else if (pick < 28) begin
            send_item(ACT_PIXEL, pick_coord(sb.x_limit), pick_coord(sb.y_limit),
                      t_coord'($urandom), t_coord'($urandom), COLOR_W'($urandom),
                      MASK_W'($urandom));
        end else begin
            act = ACTION_W'($urandom_range(ACT_FILL, ACT_BITMAP));
            px  = pick_coord(sb.x_limit);
            py  = pick_coord(sb.y_limit);
            if (act == ACT_HLINE) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) ew = '1;
                else if (pick < 20) ew = t_coord'($urandom);
                else if (pick < 60) ew = px + t_coord'($urandom_range(0, 8));
                else ew = px - t_coord'($urandom_range(0, 8));
                eh = t_coord'($urandom);
            end else begin
                ew = pick_extent();
                eh = pick_extent();
            end
            send_item(act, px, py, ew, eh, COLOR_W'($urandom), MASK_W'($urandom));
            // some runs are cut short so the next command interrupts them
            step_cap = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 3) : 64;
            n_steps  = 0;
            while (sb.run_mode != MODE_NONE && n_steps < step_cap) begin
                send_step(MASK_W'($urandom));
                n_steps++;
            end
        end
    endtask

    initial begin
        int phase_end;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset configuration
        send_step(8'h01);
        send_item(ACT_RSVD_LO, '1, '1, '1, '1, '1, '1);
        send_item(ACT_RSVD_HI, '0, '0, '0, '0, '0, '0);
        send_item(ACT_PIXEL, 10'd0, 10'd0, '0, '0, 16'hFFFF, 8'h00);
        send_item(ACT_PIXEL, 10'd319, 10'd239, '1, '1, 16'h0000, 8'hFF);
        send_item(ACT_PIXEL, 10'd320, 10'd0, '0, '0, 16'h1234, 8'h01);
        send_item(ACT_PIXEL, '1, '1, '0, '0, 16'h5678, 8'h7F);
        send_item(ACT_FILL, 10'd318, 10'd238, '1, '1, 16'hA5A5, 8'h00);
        repeat (4) send_step(8'h80);
        send_item(ACT_FILL, 10'd5, 10'd5, 10'd0, 10'd3, 16'h0F0F, 8'h00);
        send_item(ACT_BITMAP, 10'd5, 10'd5, 10'd2, 10'd0, 16'hF0F0, 8'h00);
        send_item(ACT_HLINE, 10'd9, 10'd3, 10'd7, '1, 16'h3C3C, 8'h00);
        repeat (3) send_step(8'hFF);
        send_item(ACT_HLINE, 10'd317, 10'd239, '1, '0, 16'hC3C3, 8'h00);
        repeat (3) send_step(8'h00);
        send_item(ACT_HLINE, 10'd400, 10'd0, 10'd330, '0, 16'h1111, 8'h00);
        send_item(ACT_BITMAP, 10'd318, 10'd0, 10'd3, 10'd1, 16'h2222, 8'h00);
        send_step(8'h01);
        send_step(8'h80);
        send_step(8'h7F);
        send_item(ACT_FILL, 10'd0, 10'd0, 10'd4, 10'd4, 16'h3333, 8'h00);
        send_step(8'h00);
        send_item(ACT_PIXEL, 10'd1, 10'd1, '0, '0, 16'h4444, 8'h00);
        send_step(8'h01);

        for (int phase = 0; phase < 4; phase++) begin
            wait_drain();
            case (phase)
                0: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                    set_config(32'hFFFF_FFFF, 10'd1023, 10'd1023, 4'd10);
                end
                1: begin
                    in_idle_pct   = 63;
                    out_stall_pct = 0;
                    set_config(32'h0000_0000, 10'd1, 10'd1, 4'd0);
                end
                2: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 63;
                    set_config($urandom, LIMIT_W'($urandom_range(8, 64)),
                               LIMIT_W'($urandom_range(4, 32)), SHIFT_W'($urandom_range(0, 10)));
                end
                default: begin
                    in_idle_pct   = 23;
                    out_stall_pct = 23;
                    set_config($urandom, X_LIMIT_RST, Y_LIMIT_RST, ROW_SHIFT_RST);
                end
            endcase
            // a run left open across the register change keeps its latched bounds
            if (sb.run_mode != MODE_NONE) begin
                send_step(MASK_W'($urandom));
            end
            phase_end = n_items + 180;
            while (n_items < phase_end) begin
                random_sequence();
            end
            send_item(ACT_FILL, '0, '0, 10'd3, 10'd2, COLOR_W'($urandom), MASK_W'($urandom));
            send_step(MASK_W'($urandom));
        end

        wait_drain();
        $display("covered %0d items, %0d results with %0d pixel writes, over %0d register settings",
                 n_items, sb.n_results, sb.n_writes, n_settings);
        $display("handshake mixes: no idling, sender idle, receiver stalling, both");
        if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
            $display("clipped_rect_pixel_writer: match");
        end else begin
            $display("clipped_rect_pixel_writer: mismatch");
        end
        $finish;
    end
endmodule
